>>> hw/rtl/cbf_pkg.sv
// Shared types, constants and microcode encodings of the cascaded biquad filter.
package cbf_pkg;

	localparam int MAX_STAGES_DEF     = 5;
	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 28;

	localparam int COEF_W     = 32;
	localparam int HIST_W     = 32;
	localparam int GAIN_W     = 31;
	localparam int EXTRA_W    = 3;
	localparam int ROW_W      = 4 * HIST_W;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int ACC_W      = 68;

	typedef enum logic [2:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_EXTRA,
		REG_ORDER,
		REG_GAIN
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic [EXTRA_W-1:0]       extra_stages;
		logic                     second_order;
		logic [GAIN_W-1:0]        output_gain;
		logic                     hist_clear;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MB0,
		ST_MB1,
		ST_MA1,
		ST_MB2,
		ST_MA2,
		ST_ACC,
		ST_WB,
		ST_MGAIN,
		ST_GLOAD,
		ST_OUT
	} step_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_NO_INPUT,
		JC_FIRST_ORDER,
		JC_MORE_STAGES,
		JC_OUT_BUSY
	} jump_cond_t;

	typedef enum logic [2:0] {
		MS_B0X,
		MS_B1X1,
		MS_B2X2,
		MS_A1Y1,
		MS_A2Y2,
		MS_GAIN
	} mul_sel_t;

	typedef enum logic [1:0] {
		AO_HOLD,
		AO_LOAD,
		AO_ADD
	} acc_op_t;

	typedef struct packed {
		jump_cond_t cond;
		step_t      target;
		logic       take_input;
		logic       ram_rd;
		mul_sel_t   mul_sel;
		acc_op_t    acc_op;
		logic       write_back;
		logic       out_load;
	} ctrl_word_t;

	typedef struct packed {
		logic first_order;
		logic more_stages;
		logic out_busy;
	} dp_status_t;

endpackage

>>> hw/rtl/cbf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/cbf_regs.sv
// APB-style configuration register file of the cascaded biquad filter.
module cbf_regs #(
	parameter int COEF_FRAC_BITS = cbf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cbf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [cbf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [cbf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output cbf_pkg::cfg_t                   cfg
);

	localparam logic [cbf_pkg::COEF_W-1:0] COEF_ONE = cbf_pkg::COEF_W'(1) << COEF_FRAC_BITS;
	localparam logic [cbf_pkg::GAIN_W-1:0] GAIN_ONE = cbf_pkg::GAIN_W'(1) << COEF_FRAC_BITS;

	logic signed [cbf_pkg::COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [cbf_pkg::EXTRA_W-1:0]       extra_q;
	logic                              order_q;
	logic [cbf_pkg::GAIN_W-1:0]        gain_q;
	logic                              clear_q;
	logic                              wr;
	cbf_pkg::reg_idx_t                 idx;

	assign wr  = psel & penable & pwrite;
	assign idx = cbf_pkg::reg_idx_t'(paddr[cbf_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q    <= COEF_ONE;
			b1_q    <= '0;
			b2_q    <= '0;
			a1_q    <= '0;
			a2_q    <= '0;
			extra_q <= '0;
			order_q <= 1'b1;
			gain_q  <= GAIN_ONE;
			clear_q <= 1'b0;
		end else begin
			clear_q <= wr && (idx == cbf_pkg::REG_EXTRA);
			if (wr) begin
				case (idx)
					cbf_pkg::REG_B0:    b0_q    <= pwdata;
					cbf_pkg::REG_B1:    b1_q    <= pwdata;
					cbf_pkg::REG_B2:    b2_q    <= pwdata;
					cbf_pkg::REG_A1:    a1_q    <= pwdata;
					cbf_pkg::REG_A2:    a2_q    <= pwdata;
					cbf_pkg::REG_EXTRA: extra_q <= pwdata[cbf_pkg::EXTRA_W-1:0];
					cbf_pkg::REG_ORDER: order_q <= pwdata[0];
					cbf_pkg::REG_GAIN:  gain_q  <= pwdata[cbf_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			cbf_pkg::REG_B0:    prdata = b0_q;
			cbf_pkg::REG_B1:    prdata = b1_q;
			cbf_pkg::REG_B2:    prdata = b2_q;
			cbf_pkg::REG_A1:    prdata = a1_q;
			cbf_pkg::REG_A2:    prdata = a2_q;
			cbf_pkg::REG_EXTRA: prdata = cbf_pkg::APB_DATA_W'(extra_q);
			cbf_pkg::REG_ORDER: prdata = cbf_pkg::APB_DATA_W'(order_q);
			cbf_pkg::REG_GAIN:  prdata = cbf_pkg::APB_DATA_W'(gain_q);
			default:            prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	assign cfg.b0           = b0_q;
	assign cfg.b1           = b1_q;
	assign cfg.b2           = b2_q;
	assign cfg.a1           = a1_q;
	assign cfg.a2           = a2_q;
	assign cfg.extra_stages = extra_q;
	assign cfg.second_order = order_q;
	assign cfg.output_gain  = gain_q;
	assign cfg.hist_clear   = clear_q;

endmodule

>>> hw/rtl/cbf_sequencer.sv
// Microcode store and step counter that drive the filter datapath.
module cbf_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cbf_pkg::dp_status_t status,
	output cbf_pkg::ctrl_word_t cw
);

	cbf_pkg::step_t pc_q;
	cbf_pkg::step_t pc_next;
	logic           jump;

	// One control word per step; unused fields stay at their idle values.
	function automatic cbf_pkg::ctrl_word_t rom_word(input cbf_pkg::step_t step);
		cbf_pkg::ctrl_word_t w;
		w            = '0;
		w.cond       = cbf_pkg::JC_NEVER;
		w.target     = cbf_pkg::ST_IDLE;
		w.mul_sel    = cbf_pkg::MS_B0X;
		w.acc_op     = cbf_pkg::AO_HOLD;
		case (step)
			cbf_pkg::ST_IDLE: begin
				w.take_input = 1'b1;
				w.cond       = cbf_pkg::JC_NO_INPUT;
				w.target     = cbf_pkg::ST_IDLE;
			end
			cbf_pkg::ST_READ: begin
				w.ram_rd = 1'b1;
			end
			cbf_pkg::ST_MB0: begin
				w.mul_sel = cbf_pkg::MS_B0X;
			end
			cbf_pkg::ST_MB1: begin
				w.mul_sel = cbf_pkg::MS_B1X1;
				w.acc_op  = cbf_pkg::AO_LOAD;
			end
			cbf_pkg::ST_MA1: begin
				w.mul_sel = cbf_pkg::MS_A1Y1;
				w.acc_op  = cbf_pkg::AO_ADD;
				w.cond    = cbf_pkg::JC_FIRST_ORDER;
				w.target  = cbf_pkg::ST_ACC;
			end
			cbf_pkg::ST_MB2: begin
				w.mul_sel = cbf_pkg::MS_B2X2;
				w.acc_op  = cbf_pkg::AO_ADD;
			end
			cbf_pkg::ST_MA2: begin
				w.mul_sel = cbf_pkg::MS_A2Y2;
				w.acc_op  = cbf_pkg::AO_ADD;
			end
			cbf_pkg::ST_ACC: begin
				w.acc_op = cbf_pkg::AO_ADD;
			end
			cbf_pkg::ST_WB: begin
				w.write_back = 1'b1;
				w.cond       = cbf_pkg::JC_MORE_STAGES;
				w.target     = cbf_pkg::ST_READ;
			end
			cbf_pkg::ST_MGAIN: begin
				w.mul_sel = cbf_pkg::MS_GAIN;
			end
			cbf_pkg::ST_GLOAD: begin
				w.acc_op = cbf_pkg::AO_LOAD;
			end
			cbf_pkg::ST_OUT: begin
				w.out_load = 1'b1;
				w.cond     = cbf_pkg::JC_OUT_BUSY;
				w.target   = cbf_pkg::ST_OUT;
			end
			default: begin
				w.cond   = cbf_pkg::JC_ALWAYS;
				w.target = cbf_pkg::ST_IDLE;
			end
		endcase
		return w;
	endfunction

	assign cw = rom_word(pc_q);

	always_comb begin
		case (cw.cond)
			cbf_pkg::JC_NEVER:       jump = 1'b0;
			cbf_pkg::JC_ALWAYS:      jump = 1'b1;
			cbf_pkg::JC_NO_INPUT:    jump = ~in_valid;
			cbf_pkg::JC_FIRST_ORDER: jump = status.first_order;
			cbf_pkg::JC_MORE_STAGES: jump = status.more_stages;
			cbf_pkg::JC_OUT_BUSY:    jump = status.out_busy;
			default:                 jump = 1'b1;
		endcase
	end

	always_comb begin
		if (jump) begin
			pc_next = cw.target;
		end else if (pc_q == cbf_pkg::ST_OUT) begin
			pc_next = cbf_pkg::ST_IDLE;
		end else begin
			pc_next = cbf_pkg::step_t'(4'(pc_q + 4'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= cbf_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> hw/rtl/cbf_datapath.sv
// Shared multiply-accumulate datapath, section history and output register.
module cbf_datapath #(
	parameter int MAX_STAGES     = cbf_pkg::MAX_STAGES_DEF,
	parameter int SAMPLE_WIDTH   = cbf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = cbf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cbf_pkg::cfg_t                  cfg,
	input  cbf_pkg::ctrl_word_t            cw,
	input  logic                           in_valid,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output cbf_pkg::dp_status_t            status
);

	localparam int STW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int ACC_W = cbf_pkg::ACC_W;
	localparam int HW    = cbf_pkg::HIST_W;

	localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) << (HW - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(1) << (HW - 1));
	localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] S_MIN = -(ACC_W'(1) << (SAMPLE_WIDTH - 1));

	logic signed [HW-1:0]           x_q;
	logic [STW-1:0]                 stage_q;
	logic [STW-1:0]                 last_stage;
	logic [MAX_STAGES-1:0]          hist_vld_q;
	logic                           rd_vld_q;
	logic signed [2*HW-1:0]         prod_s1;
	logic signed [ACC_W-1:0]        acc_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	logic [cbf_pkg::ROW_W-1:0] rdata;
	logic [cbf_pkg::ROW_W-1:0] row;
	logic [cbf_pkg::ROW_W-1:0] wdata;
	logic signed [HW-1:0]      x1, x2, y1, y2;
	logic signed [HW-1:0]      mul_a, mul_b;
	logic signed [ACC_W-1:0]   rnd, shf;
	logic signed [HW-1:0]      y_new;
	logic signed [SAMPLE_WIDTH-1:0] s_new;
	logic                      take;
	logic                      busy;
	logic                      wb;

	assign take = cw.take_input & in_valid;
	assign busy = out_valid_q & out_stall;
	assign wb   = cw.write_back;

	// A section whose history was cleared reads as all zero.
	assign row = rd_vld_q ? rdata : '0;
	assign x1  = row[0*HW +: HW];
	assign x2  = row[1*HW +: HW];
	assign y1  = row[2*HW +: HW];
	assign y2  = row[3*HW +: HW];

	always_comb begin
		if (int'(cfg.extra_stages) >= MAX_STAGES) begin
			last_stage = STW'(MAX_STAGES - 1);
		end else begin
			last_stage = STW'(cfg.extra_stages);
		end
	end

	always_comb begin
		case (cw.mul_sel)
			cbf_pkg::MS_B0X:  begin mul_a = cfg.b0; mul_b = x_q; end
			cbf_pkg::MS_B1X1: begin mul_a = cfg.b1; mul_b = x1;  end
			cbf_pkg::MS_B2X2: begin mul_a = cfg.b2; mul_b = x2;  end
			cbf_pkg::MS_A1Y1: begin mul_a = cfg.a1; mul_b = y1;  end
			cbf_pkg::MS_A2Y2: begin mul_a = cfg.a2; mul_b = y2;  end
			cbf_pkg::MS_GAIN: begin mul_a = signed'({1'b0, cfg.output_gain}); mul_b = x_q; end
			default:          begin mul_a = cfg.b0; mul_b = x_q; end
		endcase
	end

	// Round half up, then clamp to the section word and to the sample width.
	always_comb begin
		rnd = acc_q + HALF;
		shf = rnd >>> COEF_FRAC_BITS;
		if (shf > Y_MAX) begin
			y_new = HW'(Y_MAX);
		end else if (shf < Y_MIN) begin
			y_new = HW'(Y_MIN);
		end else begin
			y_new = HW'(shf);
		end
		if (shf > S_MAX) begin
			s_new = SAMPLE_WIDTH'(S_MAX);
		end else if (shf < S_MIN) begin
			s_new = SAMPLE_WIDTH'(S_MIN);
		end else begin
			s_new = SAMPLE_WIDTH'(shf);
		end
	end

	always_comb begin
		wdata            = row;
		wdata[0*HW +: HW] = x_q;
		wdata[2*HW +: HW] = y_new;
		if (cfg.second_order) begin
			wdata[1*HW +: HW] = x1;
			wdata[3*HW +: HW] = y1;
		end
	end

	cbf_ram #(
		.WIDTH(cbf_pkg::ROW_W),
		.DEPTH(MAX_STAGES)
	) u_hist (
		.clk  (clk),
		.we   (wb),
		.waddr(stage_q),
		.wdata(wdata),
		.re   (cw.ram_rd),
		.raddr(stage_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (cw.acc_op)
			cbf_pkg::AO_LOAD: acc_q <= ACC_W'(prod_s1);
			cbf_pkg::AO_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			default: ;
		endcase
		if (take) begin
			x_q <= HW'(sample_in);
		end else if (wb) begin
			x_q <= y_new;
		end
		if (cw.out_load && !busy) begin
			sample_out_q <= s_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= '0;
			hist_vld_q  <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				stage_q <= '0;
			end else if (wb) begin
				stage_q <= STW'(stage_q + 1'b1);
			end
			if (cfg.hist_clear) begin
				hist_vld_q <= '0;
			end else if (wb) begin
				hist_vld_q[stage_q] <= 1'b1;
			end
			if (cw.ram_rd) begin
				rd_vld_q <= hist_vld_q[stage_q];
			end
			if (cw.out_load && !busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	assign status.first_order = ~cfg.second_order;
	assign status.more_stages = (stage_q != last_stage);
	assign status.out_busy    = busy;

endmodule

>>> hw/rtl/cascaded_biquad_filter_top.sv
// Top level of the cascaded biquad filter: registers, sequencer and datapath.
// Each sample runs a history read, one multiply per tap and a write-back for every section
// (first order skips the b2 and a2 taps), then gain and output steps; one shared 32x32
// multiply serves every tap. A new sample is taken only once the previous one is through,
// and the output step waits only while an earlier result is still held by a stalled consumer.
// Reset: coefficients return to unity pass-through, history valid bits clear at once,
// so every section starts from zero history; no clearing pass is needed.
module cascaded_biquad_filter_top #(
	parameter int MAX_STAGES     = cbf_pkg::MAX_STAGES_DEF,
	parameter int SAMPLE_WIDTH   = cbf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = cbf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input sample channel.
	input  logic                           sample_in_valid,
	output logic                           sample_in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	// Result channel.
	output logic                           sample_out_valid,
	input  logic                           sample_out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	// Configuration port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cbf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cbf_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cbf_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	cbf_pkg::cfg_t       cfg;
	cbf_pkg::ctrl_word_t cw;
	cbf_pkg::dp_status_t status;

	// The register file also produces a one-cycle pulse that clears the section
	// history whenever the stage count is written.
	cbf_regs #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The sequencer steps through one short program per sample: an idle step that
	// waits for a transfer, a read of the section history, one multiply per tap,
	// a write-back that loops to the next section, then gain and output steps.
	cbf_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(sample_in_valid),
		.status  (status),
		.cw      (cw)
	);

	// Input is taken only in the idle step; the output register lets the next
	// sample start while the previous result waits for its transfer.
	assign sample_in_stall = ~cw.take_input;

	cbf_datapath #(
		.MAX_STAGES    (MAX_STAGES),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cw        (cw),
		.in_valid  (sample_in_valid),
		.sample_in (sample_in),
		.out_stall (sample_out_stall),
		.out_valid (sample_out_valid),
		.sample_out(sample_out),
		.status    (status)
	);

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the cascaded biquad filter: APB setup, sample driver, result monitor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW    = cbf_pkg::SAMPLE_WIDTH_DEF;
	localparam int FRAC  = cbf_pkg::COEF_FRAC_BITS_DEF;
	localparam int NSEC  = cbf_pkg::MAX_STAGES_DEF;
	localparam int CYCLE_LIMIT = 400_000;

	localparam logic signed [71:0] WORD_MAX = 72'sd2147483647;
	localparam logic signed [71:0] WORD_MIN = -72'sd2147483648;
	localparam logic signed [31:0] OUT_MAX  = (32'sd1 <<< (SW - 1)) - 32'sd1;
	localparam logic signed [31:0] OUT_MIN  = -OUT_MAX - 32'sd1;

	// Flavors of coefficient sets that a retune can pick.
	typedef enum int {CK_TAME, CK_WILD, CK_EDGE} coef_kind_t;
	// Receiver behavior, redrawn at random whenever the current mode runs out.
	typedef enum int {RX_FREE, RX_CHOPPY, RX_LONG} rx_mode_t;

	// The testbench's own copy of the register file.
	typedef struct {
		logic signed [31:0] b0, b1, b2, a1, a2;
		logic [2:0]         extra;
		logic               order2;
		logic [30:0]        gain;
	} filter_setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 sample_in_valid = 1'b0;
	logic                 sample_in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic                 sample_out_valid;
	logic                 sample_out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;

	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [cbf_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [cbf_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [cbf_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	// Predictor state: settings plus per-section history (x1, x2, y1, y2).
	filter_setting_t    setting;
	logic signed [31:0] hist_x1 [NSEC];
	logic signed [31:0] hist_x2 [NSEC];
	logic signed [31:0] hist_y1 [NSEC];
	logic signed [31:0] hist_y2 [NSEC];

	logic signed [SW-1:0] pending_samples [$];
	logic signed [SW-1:0] expected_outputs [$];

	logic        in_taken = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	rx_mode_t    rx_mode = RX_FREE;
	int unsigned rx_mode_left = 0;
	int unsigned rx_run_left = 0;

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned samples_sent = 0;
	int unsigned results_checked = 0;
	int unsigned register_writes = 0;
	int unsigned settings_used = 0;

	cascaded_biquad_filter_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_in_valid  (sample_in_valid),
		.sample_in_stall  (sample_in_stall),
		.sample_in        (sample_in),
		.sample_out_valid (sample_out_valid),
		.sample_out_stall (sample_out_stall),
		.sample_out       (sample_out),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always #4 clk = ~clk;

	// Exact product of two signed words, widened so that five of them can be summed
	// without any loss.
	function automatic logic signed [71:0] tap(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [71:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	// Drops the fraction bits with round-half-up and clamps to a signed word.
	function automatic logic signed [31:0] round_to_word(input logic signed [71:0] acc);
		logic signed [71:0] q;
		q = (acc + (72'sd1 <<< (FRAC - 1))) >>> FRAC;
		if (q > WORD_MAX)
			return 32'sh7fff_ffff;
		if (q < WORD_MIN)
			return 32'sh8000_0000;
		return q[31:0];
	endfunction

	// Runs one sample through the active sections, updates their history and returns
	// the gain-scaled, saturated output sample.
	function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] smp);
		logic signed [31:0] x, y;
		logic signed [71:0] acc;
		int sections;
		int s;
		x = smp;
		// Stage counts beyond the hardware size run every section there is.
		sections = (setting.extra >= NSEC) ? NSEC : setting.extra + 1;
		for (s = 0; s < sections; s++) begin
			if (setting.order2) begin
				acc = tap(setting.b0, x) + tap(setting.b1, hist_x1[s])
					+ tap(setting.b2, hist_x2[s]) + tap(setting.a1, hist_y1[s])
					+ tap(setting.a2, hist_y2[s]);
				y = round_to_word(acc);
				hist_x2[s] = hist_x1[s];
				hist_x1[s] = x;
				hist_y2[s] = hist_y1[s];
				hist_y1[s] = y;
			end else begin
				// First order leaves the second history slots untouched.
				acc = tap(setting.b0, x) + tap(setting.b1, hist_x1[s])
					+ tap(setting.a1, hist_y1[s]);
				y = round_to_word(acc);
				hist_x1[s] = x;
				hist_y1[s] = y;
			end
			x = y;
		end
		y = round_to_word(tap(x, {1'b0, setting.gain}));
		if (y > OUT_MAX)
			y = OUT_MAX;
		if (y < OUT_MIN)
			y = OUT_MIN;
		return y[SW-1:0];
	endfunction

	function automatic void clear_history();
		for (int s = 0; s < NSEC; s++) begin
			hist_x1[s] = '0;
			hist_x2[s] = '0;
			hist_y1[s] = '0;
			hist_y2[s] = '0;
		end
	endfunction

	function automatic void flag_mismatch(input string detail);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH at %0t: %s", $realtime, detail);
	endfunction

	// One APB write: setup cycle, then access cycle until pready. The shadow copy is
	// updated once the register has taken the value.
	task automatic write_register(input cbf_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		register_writes++;
		case (idx)
			cbf_pkg::REG_B0: setting.b0 = value;
			cbf_pkg::REG_B1: setting.b1 = value;
			cbf_pkg::REG_B2: setting.b2 = value;
			cbf_pkg::REG_A1: setting.a1 = value;
			cbf_pkg::REG_A2: setting.a2 = value;
			// Any write of the stage count wipes all history, even with the same value.
			cbf_pkg::REG_EXTRA: begin
				setting.extra = value[2:0];
				clear_history();
			end
			cbf_pkg::REG_ORDER: setting.order2 = value[0];
			cbf_pkg::REG_GAIN:  setting.gain = value[30:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return OUT_MAX[SW-1:0];
			1: return OUT_MIN[SW-1:0];
			2, 3, 4: return SW'(int'($urandom_range(0, 2000)) - 1000);
			default: return SW'($urandom());
		endcase
	endfunction

	// Picks a register value. Narrow registers sometimes carry junk above their width,
	// which the block has to ignore.
	function automatic logic [31:0] pick_value(input cbf_pkg::reg_idx_t idx,
			input coef_kind_t kind);
		logic [31:0] junk;
		junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
		case (idx)
			cbf_pkg::REG_EXTRA: return (junk & ~32'h7) | $urandom_range(0, 7);
			cbf_pkg::REG_ORDER: return (junk & ~32'h1) | $urandom_range(0, 1);
			cbf_pkg::REG_GAIN: begin
				if (kind == CK_WILD)
					return $urandom();
				if (kind == CK_EDGE)
					return $urandom_range(0, 1) ? 32'h7fff_ffff : (junk & 32'h8000_0000);
				return (junk & 32'h8000_0000) | $urandom_range(32'h0400_0000, 32'h2000_0000);
			end
			default: begin
				if (kind == CK_WILD)
					return $urandom();
				if (kind == CK_EDGE) begin
					case ($urandom_range(0, 4))
						0: return 32'h7fff_ffff;
						1: return 32'h8000_0000;
						2: return 32'h0000_0000;
						3: return 32'h1000_0000;
						default: return 32'hf000_0000;
					endcase
				end
				// Tame sets stay inside the stable region so the history keeps
				// carrying meaningful values: |a1| < 0.85, -0.9 <= a2 <= 0.1.
				if (idx == cbf_pkg::REG_A1)
					return int'($urandom_range(0, 32'h1b33_3334)) - 32'sh0d99_999a;
				if (idx == cbf_pkg::REG_A2)
					return int'($urandom_range(0, 32'h1000_0000)) - 32'sh0e66_6666;
				return int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
			end
		endcase
	endfunction

	// Rewrites some or all registers. Skipping the stage count keeps the history, so
	// an order change then runs on top of the old state.
	task automatic retune_filter(input bit everything);
		coef_kind_t kind;
		cbf_pkg::reg_idx_t idx;
		int unsigned roll;
		roll = $urandom_range(0, 19);
		kind = (roll < 12) ? CK_TAME : (roll < 17) ? CK_WILD : CK_EDGE;
		idx = idx.first();
		do begin
			if (everything || $urandom_range(0, 2) != 0)
				write_register(idx, pick_value(idx, kind));
			idx = idx.next();
		end while (idx != idx.first());
	endtask

	// Queues a batch of samples and waits until each of them has come back, so that
	// the block is idle afterwards and may be reconfigured.
	task automatic run_batch(input logic signed [SW-1:0] batch [$]);
		settings_used++;
		foreach (batch[i])
			pending_samples.push_back(batch[i]);
		@(posedge clk);
		while (pending_samples.size() != 0 || sample_in_valid || expected_outputs.size() != 0)
			@(posedge clk);
	endtask

	// Input side, sampled at the rising edge: every accepted transfer is run through
	// the predictor right away and its output is queued for the monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= sample_in_valid && !sample_in_stall;
			if (sample_in_valid && !sample_in_stall) begin
				expected_outputs.push_back(filter_sample(sample_in));
				samples_sent++;
			end
		end
	end

	// Driver: works in bursts of random length separated by random gaps. A payload is
	// only replaced once the transfer that carried it has happened, so a stalled
	// sample holds still.
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_in_valid <= 1'b0;
		end else if (!sample_in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				sample_in_valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				sample_in_valid <= 1'b1;
				sample_in <= pending_samples.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					// A quarter of the bursts run straight on with no gap at all.
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				sample_in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: free-running, choppy, or long stall runs, each mode
	// held until its random countdown runs out.
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_mode_left <= $urandom_range(50, 300);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_FREE: sample_out_stall <= 1'b0;
			RX_CHOPPY: sample_out_stall <= 1'($urandom_range(0, 1));
			default: begin
				if (rx_run_left == 0) begin
					sample_out_stall <= ~sample_out_stall;
					rx_run_left <= $urandom_range(1, 25);
				end else begin
					rx_run_left <= rx_run_left - 1;
				end
			end
		endcase
	end

	// Monitor: each result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && sample_out_valid && !sample_out_stall) begin
			if (expected_outputs.size() == 0) begin
				flag_mismatch($sformatf("sample_out %0d arrived with nothing expected",
					sample_out));
			end else begin
				logic signed [SW-1:0] want;
				want = expected_outputs.pop_front();
				results_checked++;
				if (sample_out !== want)
					flag_mismatch($sformatf("sample_out expected %0d, got %0d",
						want, sample_out));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Watchdog expired after %0d cycles, %0d results still outstanding",
				cycle_count, expected_outputs.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		logic signed [SW-1:0] batch [$];
		int unsigned n;

		// Shadow registers start at their reset values: unity single biquad.
		setting.b0 = 32'h1000_0000;
		setting.b1 = '0;
		setting.b2 = '0;
		setting.a1 = '0;
		setting.a2 = '0;
		setting.extra = '0;
		setting.order2 = 1'b1;
		setting.gain = 31'h1000_0000;
		clear_history();

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings pass samples straight through: field extremes and bit patterns.
		batch = '{OUT_MAX[SW-1:0], OUT_MIN[SW-1:0], 0, -1, 1, 24'sh555555, -24'sh555556};
		run_batch(batch);

		// Full-scale taps on five sections with maximum gain drive every section into
		// its word saturation, both ways.
		write_register(cbf_pkg::REG_B0, 32'h7fff_ffff);
		write_register(cbf_pkg::REG_B1, 32'h8000_0000);
		write_register(cbf_pkg::REG_B2, 32'h7fff_ffff);
		write_register(cbf_pkg::REG_A1, 32'h8000_0000);
		write_register(cbf_pkg::REG_A2, 32'h7fff_ffff);
		write_register(cbf_pkg::REG_EXTRA, 32'd4);
		write_register(cbf_pkg::REG_GAIN, 32'h7fff_ffff);
		batch = '{OUT_MAX[SW-1:0], OUT_MIN[SW-1:0], OUT_MAX[SW-1:0], OUT_MIN[SW-1:0], 0};
		run_batch(batch);

		// First order, stage count above the section count, junk above the narrow registers'
		// width; the gain write lands on 1.0 once its top bit is dropped.
		write_register(cbf_pkg::REG_B0, 32'h8000_0000);
		write_register(cbf_pkg::REG_B1, 32'h0800_0000);
		write_register(cbf_pkg::REG_B2, 32'h0000_0000);
		write_register(cbf_pkg::REG_A1, 32'hf800_0000);
		write_register(cbf_pkg::REG_A2, 32'h0000_0000);
		write_register(cbf_pkg::REG_EXTRA, 32'hffff_ffff);
		write_register(cbf_pkg::REG_ORDER, 32'hffff_fffe);
		write_register(cbf_pkg::REG_GAIN, 32'h9000_0000);
		batch = '{1000, -1000, OUT_MAX[SW-1:0], OUT_MIN[SW-1:0]};
		run_batch(batch);

		// Switching back to biquads keeps whatever history the first-order run left.
		write_register(cbf_pkg::REG_ORDER, 32'd1);
		batch = '{500, 0, 0};
		run_batch(batch);

		// Rewriting the same stage count still clears the history.
		write_register(cbf_pkg::REG_EXTRA, 32'd7);
		batch = '{0, 100};
		run_batch(batch);

		// Zero gain mutes the output.
		write_register(cbf_pkg::REG_GAIN, 32'd0);
		batch = '{OUT_MAX[SW-1:0]};
		run_batch(batch);

		// Random part: mostly tame coefficient sets that keep the sections alive, with
		// wild and corner sets mixed in. Each batch runs on one setting.
		retune_filter(1'b1);
		while (samples_sent < 550) begin
			n = $urandom_range(8, 40);
			batch = {};
			repeat (n)
				batch.push_back(pick_sample());
			run_batch(batch);
			retune_filter(1'b0);
		end

		// Let any stray result surface before judging the run.
		repeat (64) @(posedge clk);
		if (expected_outputs.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived",
				expected_outputs.size()));

		$display("Sent %0d samples over %0d filter settings with %0d register writes.",
			samples_sent, settings_used, register_writes);
		$display("Checked %0d results: one to five sections, both orders, saturation.",
			results_checked);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
